[hw/rtl/gpio_port_register_block_macros.svh]
// ----------------------------------------------------------------------------
// GPIO port register block assertion macros
// Concurrent assertion shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef GPIO_PORT_REGISTER_BLOCK_MACROS_SVH
`define GPIO_PORT_REGISTER_BLOCK_MACROS_SVH

// Same-cycle implication.
`define GPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/gpr_pkg.sv]
// ----------------------------------------------------------------------------
// GPIO port register block package
// Payload types, status and mode codes, register offsets, queue job type.
// ----------------------------------------------------------------------------
package gpr_pkg;

  localparam int PIN_MAX     = 16;
  localparam int PIN_COUNT   = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [9:0] OFS_MODE_LO   = 10'h000;
  localparam logic [9:0] OFS_MODE_HI   = 10'h004;
  localparam logic [9:0] OFS_INPUT     = 10'h008;
  localparam logic [9:0] OFS_OUTPUT    = 10'h00C;
  localparam logic [9:0] OFS_SET_RESET = 10'h010;
  localparam logic [9:0] OFS_RESET     = 10'h014;
  localparam logic [9:0] OFS_LOCK      = 10'h018;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_PIN   = 2'd2
  } gpr_mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNALIGNED = 2'd1,
    ST_FAULT     = 2'd2,
    ST_READ_ONLY = 2'd3
  } gpr_status_t;

  typedef enum logic {
    KIND_RESP = 1'b0,
    KIND_PIN  = 1'b1
  } gpr_kind_t;

  typedef struct packed {
    gpr_mode_t   mode;
    logic [9:0]  offset;
    logic        access_word;
    logic [31:0] write_data;
    logic [4:0]  pin_index;
    logic        pin_level;
  } gpr_in_t;

  typedef struct packed {
    gpr_kind_t   kind;
    logic [31:0] read_data;
    gpr_status_t status;
    logic [3:0]  changed_pin;
    logic        new_level;
    logic        last;
  } gpr_out_t;

  typedef struct packed {
    logic [PIN_MAX-1:0] change_mask;
    logic [PIN_MAX-1:0] levels;
    logic [31:0]        read_data;
    gpr_status_t        status;
  } gpr_job_t;

endpackage

[hw/rtl/gpr_front.sv]
// ----------------------------------------------------------------------------
// GPIO port front end
// Decode bus accesses and pin events, update registers, queue a job per bus access.
// ----------------------------------------------------------------------------
module gpr_front #(
  parameter int PIN_COUNT = gpr_pkg::PIN_COUNT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  gpr_pkg::gpr_in_t in_data,
  input  logic             q_full,
  output logic             in_stall,
  output logic             q_push,
  output gpr_pkg::gpr_job_t q_job
);

  localparam logic [gpr_pkg::PIN_MAX-1:0] PIN_MASK =
    gpr_pkg::PIN_MAX'((33'd1 << PIN_COUNT) - 33'd1);

  logic [31:0]                mode_lo_r, mode_lo_nxt;
  logic [31:0]                mode_hi_r, mode_hi_nxt;
  logic [gpr_pkg::PIN_MAX-1:0] in_lvl_r, in_lvl_nxt;
  logic [31:0]                out_lvl_r, out_lvl_nxt;
  logic [31:0]                lock_r, lock_nxt;
  logic                       accept;
  logic [31:0]                rdata;
  gpr_pkg::gpr_status_t       status;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    mode_lo_nxt = mode_lo_r;
    mode_hi_nxt = mode_hi_r;
    in_lvl_nxt  = in_lvl_r;
    out_lvl_nxt = out_lvl_r;
    lock_nxt    = lock_r;
    rdata       = 32'd0;
    status      = gpr_pkg::ST_OK;
    q_push      = 1'b0;
    case (in_data.mode)
      gpr_pkg::MODE_PIN: begin
        if (32'(in_data.pin_index) < 32'(PIN_COUNT)) begin
          in_lvl_nxt[in_data.pin_index[3:0]] = in_data.pin_level;
        end
      end
      gpr_pkg::MODE_READ: begin
        q_push = accept;
        if (!in_data.access_word) begin
          status = gpr_pkg::ST_UNALIGNED;
        end else begin
          case (in_data.offset)
            gpr_pkg::OFS_MODE_LO: rdata = mode_lo_r;
            gpr_pkg::OFS_MODE_HI: rdata = mode_hi_r;
            gpr_pkg::OFS_INPUT:   rdata = {16'd0, in_lvl_r};
            gpr_pkg::OFS_OUTPUT:  rdata = out_lvl_r;
            gpr_pkg::OFS_LOCK:    rdata = lock_r;
            default:              status = gpr_pkg::ST_FAULT;
          endcase
        end
      end
      gpr_pkg::MODE_WRITE: begin
        q_push = accept;
        if (!in_data.access_word) begin
          status = gpr_pkg::ST_UNALIGNED;
        end else begin
          case (in_data.offset)
            gpr_pkg::OFS_MODE_LO:   mode_lo_nxt = in_data.write_data;
            gpr_pkg::OFS_MODE_HI:   mode_hi_nxt = in_data.write_data;
            gpr_pkg::OFS_INPUT:     status = gpr_pkg::ST_READ_ONLY;
            gpr_pkg::OFS_OUTPUT:    out_lvl_nxt = in_data.write_data;
            gpr_pkg::OFS_SET_RESET: out_lvl_nxt =
              (out_lvl_r | {16'd0, in_data.write_data[15:0]})
              & ~{16'd0, in_data.write_data[31:16]};
            gpr_pkg::OFS_RESET:     out_lvl_nxt =
              out_lvl_r & ~{16'd0, in_data.write_data[15:0]};
            gpr_pkg::OFS_LOCK:      lock_nxt = in_data.write_data;
            default:                status = gpr_pkg::ST_FAULT;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  assign q_job.change_mask = (out_lvl_r[15:0] ^ out_lvl_nxt[15:0]) & PIN_MASK;
  assign q_job.levels      = out_lvl_nxt[15:0];
  assign q_job.read_data   = rdata;
  assign q_job.status      = status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_lo_r <= 32'd0;
      mode_hi_r <= 32'd0;
      in_lvl_r  <= '0;
      out_lvl_r <= 32'd0;
      lock_r    <= 32'd0;
    end else if (accept) begin
      mode_lo_r <= mode_lo_nxt;
      mode_hi_r <= mode_hi_nxt;
      in_lvl_r  <= in_lvl_nxt;
      out_lvl_r <= out_lvl_nxt;
      lock_r    <= lock_nxt;
    end
  end

endmodule

[hw/rtl/gpr_queue.sv]
// ----------------------------------------------------------------------------
// GPIO port job queue
// Small FIFO between the decode front end and the result sequencer.
// ----------------------------------------------------------------------------
module gpr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gpr_pkg::gpr_job_t push_job,
  input  logic              pop,
  output logic              full,
  output logic              q_valid,
  output gpr_pkg::gpr_job_t q_job
);

  localparam int PW = $clog2(gpr_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(gpr_pkg::QUEUE_DEPTH + 1);

  gpr_pkg::gpr_job_t slot_r [gpr_pkg::QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = count_r == CW'(gpr_pkg::QUEUE_DEPTH);
  assign q_valid = count_r != '0;
  assign q_job   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(gpr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(gpr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[hw/rtl/gpr_back.sv]
// ----------------------------------------------------------------------------
// GPIO port result sequencer
// Emit one change word per changed pin in ascending order, then the response.
// ----------------------------------------------------------------------------
module gpr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  gpr_pkg::gpr_job_t q_job,
  output logic              q_pop,
  input  logic              out_stall,
  output logic              out_valid,
  output gpr_pkg::gpr_out_t out_data
);

  logic                        busy_r, busy_nxt;
  gpr_pkg::gpr_job_t           job_r, job_nxt;
  logic                        out_valid_r, out_valid_nxt;
  gpr_pkg::gpr_out_t           out_data_r, out_data_nxt;
  logic                        out_free;
  logic [3:0]                  low_pin;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = !busy_r && q_valid;

  always_comb begin
    low_pin = 4'd0;
    for (int i = gpr_pkg::PIN_MAX - 1; i >= 0; i--) begin
      if (job_r.change_mask[i]) begin
        low_pin = 4'(i);
      end
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    job_nxt       = job_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (!busy_r) begin
      if (q_valid) begin
        busy_nxt = 1'b1;
        job_nxt  = q_job;
      end
    end else if (out_free) begin
      out_valid_nxt = 1'b1;
      if (job_r.change_mask != '0) begin
        out_data_nxt.kind        = gpr_pkg::KIND_PIN;
        out_data_nxt.read_data   = 32'd0;
        out_data_nxt.status      = gpr_pkg::ST_OK;
        out_data_nxt.changed_pin = low_pin;
        out_data_nxt.new_level   = job_r.levels[low_pin];
        out_data_nxt.last        = 1'b0;
        job_nxt.change_mask[low_pin] = 1'b0;
      end else begin
        out_data_nxt.kind        = gpr_pkg::KIND_RESP;
        out_data_nxt.read_data   = job_r.read_data;
        out_data_nxt.status      = job_r.status;
        out_data_nxt.changed_pin = 4'd0;
        out_data_nxt.new_level   = 1'b0;
        out_data_nxt.last        = 1'b1;
        busy_nxt                 = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/gpio_port_register_block.sv]
// Path: an accepted bus access is written into the job queue, loaded into the
// result sequencer's job register, and its first result word is registered.
// The sequencer loads one job at a time and, while out_stall is low, emits one
// word a cycle; pin events emit nothing; a 2-deep job queue absorbs bursts.
// Reset: synchronous active-low rst_n clears all port registers to zero
// and empties the queue and output stage.
// ----------------------------------------------------------------------------
// GPIO port register block
// Bus register access with bit set/reset and per-pin output change records.
// ----------------------------------------------------------------------------
module gpio_port_register_block #(
  parameter int PIN_COUNT = gpr_pkg::PIN_COUNT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gpr_pkg::gpr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gpr_pkg::gpr_out_t out_data
);

  logic              push, pop, full, q_valid;
  gpr_pkg::gpr_job_t push_job, q_job;

  gpr_front #(
    .PIN_COUNT(PIN_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (full),
    .in_stall (in_stall),
    .q_push   (push),
    .q_job    (push_job)
  );

  gpr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (full),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  gpr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[hw/rtl/gpr_checker.sv]
// ----------------------------------------------------------------------------
// GPIO port result checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "gpio_port_register_block_macros.svh"

module gpr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input gpr_pkg::gpr_out_t out_data
);

  `GPR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result word changed")
  `GPR_ASSERT_NOW(a_pin_word, clk, rst_n, out_valid && out_data.kind == gpr_pkg::KIND_PIN, !out_data.last && out_data.read_data == 32'd0 && out_data.status == gpr_pkg::ST_OK, "bad change record word")
  `GPR_ASSERT_NOW(a_resp_word, clk, rst_n, out_valid && out_data.kind == gpr_pkg::KIND_RESP, out_data.last && out_data.changed_pin == 4'd0 && !out_data.new_level, "bad response word")
  `GPR_ASSERT_NEXT(a_pin_order, clk, rst_n, out_valid && !out_stall && out_data.kind == gpr_pkg::KIND_PIN, !(out_valid && out_data.kind == gpr_pkg::KIND_PIN) || out_data.changed_pin > $past(out_data.changed_pin), "change records out of pin order")

endmodule

bind gpio_port_register_block gpr_checker u_gpr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[verif/tb_gpio_port_register_block.sv]
// ----------------------------------------------------------------------------
// GPIO port register block testbench
// Drives bus reads, bus writes and pin events through the valid/stall input
// channel and checks every result word against an in-bench port model:
// register contents, access status codes and the per-pin output change
// records that come ahead of each write response. Sender bursts, receiver
// stalls and a long receiver hold-off exercise the job queue and back-pressure.
// ----------------------------------------------------------------------------
module tb_gpio_port_register_block;
  timeunit 1ns;
  timeprecision 1ps;

  import gpr_pkg::*;

  localparam int         CYCLE_LIMIT   = 300000;
  localparam int         SETTLE_CYCLES = 24;
  localparam int         REPORT_LINES  = 40;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  gpr_in_t  in_data;
  logic     out_valid;
  logic     out_stall = 1'b0;
  gpr_out_t out_data;

  logic [31:0] mode_lo_q  = '0;
  logic [31:0] mode_hi_q  = '0;
  logic [15:0] port_in_q  = '0;
  logic [31:0] port_out_q = '0;
  logic [31:0] lock_q     = '0;

  gpr_out_t pending_words[$];

  int mismatches  = 0;
  int cycle_count = 0;
  int gap_max     = 0;
  int burst_max   = 1;
  int burst_left  = 0;
  int stall_pct   = 0;
  int stall_run   = 0;
  int holdoff_req_len = 0;
  int holdoff_req_seq = 0;
  int holdoff_ack_seq = 0;
  int holdoff_left    = 0;

  gpio_port_register_block #(
    .PIN_COUNT(PIN_COUNT)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("gpio_port_register_block regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= REPORT_LINES)
      $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, want, cycle_count);
  endtask

  task automatic predict_word(input gpr_in_t w);
    gpr_out_t    r;
    gpr_status_t st;
    logic [31:0] rd;
    logic [31:0] prior;
    logic [31:0] diff;
    st = ST_OK;
    rd = '0;
    if (w.mode == MODE_PIN) begin
      if (w.pin_index < PIN_COUNT) port_in_q[w.pin_index[3:0]] = w.pin_level;
    end else if (w.mode == MODE_READ || w.mode == MODE_WRITE) begin
      if (!w.access_word) begin
        st = ST_UNALIGNED;
      end else if (w.mode == MODE_READ) begin
        case (w.offset)
          OFS_MODE_LO: rd = mode_lo_q;
          OFS_MODE_HI: rd = mode_hi_q;
          OFS_INPUT:   rd = {16'h0000, port_in_q};
          OFS_OUTPUT:  rd = port_out_q;
          OFS_LOCK:    rd = lock_q;
          default:     st = ST_FAULT;
        endcase
      end else begin
        prior = port_out_q;
        case (w.offset)
          OFS_MODE_LO:   mode_lo_q = w.write_data;
          OFS_MODE_HI:   mode_hi_q = w.write_data;
          OFS_INPUT:     st = ST_READ_ONLY;
          OFS_OUTPUT:    port_out_q = w.write_data;
          OFS_SET_RESET: port_out_q = (port_out_q | {16'h0000, w.write_data[15:0]})
                                      & ~{16'h0000, w.write_data[31:16]};
          OFS_RESET:     port_out_q = port_out_q & ~{16'h0000, w.write_data[15:0]};
          OFS_LOCK:      lock_q = w.write_data;
          default:       st = ST_FAULT;
        endcase
        diff = prior ^ port_out_q;
        for (int i = 0; i < PIN_COUNT; i++) begin
          if (diff[i]) begin
            r = '0;
            r.kind        = KIND_PIN;
            r.changed_pin = i[3:0];
            r.new_level   = port_out_q[i];
            pending_words.push_back(r);
          end
        end
      end
      r = '0;
      r.kind      = KIND_RESP;
      r.read_data = rd;
      r.status    = st;
      r.last      = 1'b1;
      pending_words.push_back(r);
    end
  endtask

  always @(posedge clk) begin : check_results
    gpr_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", out_data.read_data, '0);
      end else begin
        want = pending_words.pop_front();
        if (out_data.kind !== want.kind)
          report_mismatch("kind", 32'(out_data.kind), 32'(want.kind));
        if (out_data.read_data !== want.read_data)
          report_mismatch("read_data", out_data.read_data, want.read_data);
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.changed_pin !== want.changed_pin)
          report_mismatch("changed_pin", 32'(out_data.changed_pin), 32'(want.changed_pin));
        if (out_data.new_level !== want.new_level)
          report_mismatch("new_level", 32'(out_data.new_level), 32'(want.new_level));
        if (out_data.last !== want.last)
          report_mismatch("last", 32'(out_data.last), 32'(want.last));
      end
    end
  end

  always @(negedge clk) begin
    if (holdoff_req_seq != holdoff_ack_seq) begin
      holdoff_ack_seq = holdoff_req_seq;
      holdoff_left    = holdoff_req_len;
    end
    if (holdoff_left > 0) begin
      out_stall = 1'b1;
      holdoff_left--;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      out_stall = ($urandom_range(0, 99) < stall_pct);
      stall_run = $urandom_range(0, 3);
    end
  end

  task automatic send_word(input gpr_in_t w);
    if (gap_max > 0 && burst_left <= 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, gap_max)) @(negedge clk);
      burst_left = $urandom_range(1, burst_max);
    end
    in_data  = w;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(w);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
  endtask

  function automatic gpr_in_t make_word(input logic [1:0] m, input logic [9:0] ofs,
                                        input logic aw, input logic [31:0] d,
                                        input logic [4:0] pin, input logic lvl);
    gpr_in_t w;
    w.mode        = gpr_mode_t'(m);
    w.offset      = ofs;
    w.access_word = aw;
    w.write_data  = d;
    w.pin_index   = pin;
    w.pin_level   = lvl;
    return w;
  endfunction

  function automatic logic [9:0] pick_offset();
    case ($urandom_range(0, 6))
      0:       return OFS_MODE_LO;
      1:       return OFS_MODE_HI;
      2:       return OFS_INPUT;
      3:       return OFS_OUTPUT;
      4:       return OFS_SET_RESET;
      5:       return OFS_RESET;
      default: return OFS_LOCK;
    endcase
  endfunction

  function automatic gpr_in_t rand_word();
    gpr_in_t w;
    int      sel;
    w = make_word(MODE_WRITE, OFS_OUTPUT, 1'b1, $urandom, 5'($urandom_range(0, 31)),
                  1'($urandom_range(0, 1)));
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      w.write_data = $urandom;
    end else if (sel < 30) begin
      w.write_data = port_out_q ^ (32'h1 << $urandom_range(0, 31))
                     ^ (32'h1 << $urandom_range(0, 15));
    end else if (sel < 40) begin
      w.offset = OFS_SET_RESET;
    end else if (sel < 45) begin
      w.offset = OFS_RESET;
    end else if (sel < 65) begin
      w.mode   = MODE_READ;
      w.offset = pick_offset();
    end else if (sel < 80) begin
      w.mode = MODE_PIN;
    end else if (sel < 87) begin
      w.offset = pick_offset();
    end else if (sel < 94) begin
      w.mode        = gpr_mode_t'($urandom_range(0, 3));
      w.offset      = 10'($urandom);
      w.access_word = 1'($urandom_range(0, 1));
    end else begin
      w.mode        = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
      w.offset      = pick_offset();
      w.access_word = 1'b0;
    end
    return w;
  endfunction

  task automatic test_reset_values();
    send_word(make_word(MODE_READ, OFS_MODE_LO, 1'b1, '0, '0, 1'b0));
    send_word(make_word(MODE_READ, OFS_MODE_HI, 1'b1, '0, '0, 1'b0));
    send_word(make_word(MODE_READ, OFS_INPUT, 1'b1, '0, '0, 1'b0));
    send_word(make_word(MODE_READ, OFS_OUTPUT, 1'b1, '0, '0, 1'b0));
    send_word(make_word(MODE_READ, OFS_LOCK, 1'b1, '0, '0, 1'b0));
  endtask

  task automatic test_access_faults();
    send_word(make_word(MODE_READ, OFS_SET_RESET, 1'b1, '0, '0, 1'b0));
    send_word(make_word(MODE_READ, 10'h3FF, 1'b1, '0, '0, 1'b0));
    send_word(make_word(MODE_WRITE, 10'h3FC, 1'b1, 32'hFFFF_FFFF, '0, 1'b0));
    send_word(make_word(MODE_READ, OFS_OUTPUT, 1'b0, '0, '0, 1'b0));
    send_word(make_word(MODE_WRITE, OFS_OUTPUT, 1'b0, 32'hFFFF_FFFF, '0, 1'b0));
    send_word(make_word(MODE_WRITE, OFS_INPUT, 1'b1, 32'hFFFF_FFFF, '0, 1'b0));
  endtask

  task automatic test_register_storage();
    send_word(make_word(MODE_WRITE, OFS_MODE_LO, 1'b1, 32'hFFFF_FFFF, '0, 1'b0));
    send_word(make_word(MODE_WRITE, OFS_MODE_HI, 1'b1, 32'hA5A5_5A5A, '0, 1'b0));
    send_word(make_word(MODE_WRITE, OFS_LOCK, 1'b1, 32'hFFFF_FFFF, '0, 1'b0));
    send_word(make_word(MODE_READ, OFS_MODE_LO, 1'b1, '0, '0, 1'b0));
  endtask

  task automatic test_output_changes();
    send_word(make_word(MODE_WRITE, OFS_OUTPUT, 1'b1, 32'hFFFF_FFFF, '0, 1'b0));
    send_word(make_word(MODE_WRITE, OFS_OUTPUT, 1'b1, 32'h0000_FFFF, '0, 1'b0));
    send_word(make_word(MODE_WRITE, OFS_SET_RESET, 1'b1, 32'h0003_0004, '0, 1'b0));
    send_word(make_word(MODE_WRITE, OFS_RESET, 1'b1, 32'hFFFF_FFFF, '0, 1'b0));
    send_word(make_word(MODE_WRITE, OFS_SET_RESET, 1'b1, 32'h0000_FFFF, '0, 1'b0));
    send_word(make_word(MODE_READ, OFS_OUTPUT, 1'b1, '0, '0, 1'b0));
  endtask

  task automatic test_pin_events();
    send_word(make_word(MODE_PIN, '0, 1'b0, '0, 5'd0, 1'b1));
    send_word(make_word(MODE_PIN, '0, 1'b1, '0, 5'd15, 1'b1));
    send_word(make_word(MODE_PIN, '0, 1'b1, '0, 5'd16, 1'b1));
    send_word(make_word(MODE_PIN, '0, 1'b1, '0, 5'd31, 1'b1));
    send_word(make_word(MODE_UNUSED, OFS_OUTPUT, 1'b1, '0, '0, 1'b0));
    send_word(make_word(MODE_READ, OFS_INPUT, 1'b1, '0, '0, 1'b0));
  endtask

  task automatic test_random_traffic(input int count, input int gaps, input int stalls);
    gap_max   = gaps;
    burst_max = 8;
    stall_pct = stalls;
    repeat (count) send_word(rand_word());
    wait_drained();
  endtask

  task automatic test_backpressure();
    gap_max   = 0;
    stall_pct = 0;
    holdoff_req_len = 400;
    holdoff_req_seq++;
    repeat (40) send_word(rand_word());
    wait_drained();
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    gap_max   = 3;
    burst_max = 4;
    stall_pct = 20;
    test_reset_values();
    test_access_faults();
    test_register_storage();
    test_output_changes();
    test_pin_events();
    wait_drained();

    test_random_traffic(95, 0, 0);
    test_random_traffic(95, 4, 30);
    test_backpressure();
    test_random_traffic(95, 12, 75);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("gpio_port_register_block regression: pass");
    end else begin
      $display("gpio_port_register_block regression: fail");
    end
    $finish;
  end

endmodule
